FILE: sv/sobel_edge_double_threshold_top_macros.svh
// Assertion macros shared by the edge classifier RTL.
`ifndef SOBEL_EDGE_DOUBLE_THRESHOLD_TOP_MACROS_SVH
`define SOBEL_EDGE_DOUBLE_THRESHOLD_TOP_MACROS_SVH

`ifndef SYNTHESIS
// ante true at an edge implies cons at the same edge
`define SEDT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
// ante true at an edge implies cons at the next edge
`define SEDT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SEDT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SEDT_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: sv/sedt_pkg.sv
// Shared types and constants for the Sobel double-threshold edge classifier.
`timescale 1ns / 1ps

package sedt_pkg;

	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;

	localparam int CFG_DATA_W = 21;
	localparam int CFG_IDX_W  = 2;
	localparam int DIM_W      = 12;
	localparam int THR_W      = 21;
	localparam int POS_W      = 11;
	localparam int GRAD_W     = 11;
	localparam int MAG_W      = 21;

	localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 12'd2048;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 12'd2048;
	localparam logic [THR_W-1:0] LOW_THR_RST      = 21'd9500;
	localparam logic [THR_W-1:0] HIGH_THR_RST     = 21'd10000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_LOW_THR      = 2'd2,
		REG_HIGH_THR     = 2'd3
	} sedt_reg_t;

	typedef enum logic [1:0] {
		EDGE_NONE   = 2'd0,
		EDGE_WEAK   = 2'd1,
		EDGE_STRONG = 2'd2
	} sedt_class_t;

	// gradient stage payload
	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic [POS_W-1:0]         row;
		logic [POS_W-1:0]         col;
		logic                     frame_end;
	} sedt_grad_t;

	// floor((r+g+b)/3) as a multiply by 683/2048, exact for sums up to 765
	function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
	                                        input logic [7:0] b);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = 10'(r) + 10'(g) + 10'(b);
		prod = 20'(sum) * 20'd683;
		return prod[18:11];
	endfunction

endpackage

FILE: sv/sedt_pix_if.sv
// Pixel input channel: valid/ready with one RGB pixel.
`timescale 1ns / 1ps

interface sedt_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

FILE: sv/sedt_edge_if.sv
// Result channel: valid/ready with one classified interior pixel.
`timescale 1ns / 1ps

interface sedt_edge_if;
	logic        valid;
	logic        ready;
	logic [1:0]  edge_class;
	logic [10:0] pixel_row;
	logic [10:0] pixel_col;
	logic        frame_end;

	modport source (output valid, output edge_class, output pixel_row, output pixel_col,
	                output frame_end, input ready);
	modport sink (input valid, input edge_class, input pixel_row, input pixel_col,
	              input frame_end, output ready);
endinterface

FILE: sv/sedt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`timescale 1ns / 1ps

module sedt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/sedt_window.sv
// Raster position, gray conversion, line stores, 3x3 window and Sobel gradients.
`timescale 1ns / 1ps
`include "sobel_edge_double_threshold_top_macros.svh"

module sedt_window #(
	parameter int MAX_WIDTH  = sedt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sedt_pkg::MAX_HEIGHT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sedt_pix_if.sink                           pix,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]     frame_w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0]    frame_h,
	output logic                               grad_valid,
	input  logic                               grad_ready,
	output sedt_pkg::sedt_grad_t               grad
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = sedt_pkg::POS_W;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          col_wrap;
	logic [CW-1:0] c;
	logic [HW-1:0] row_p;
	logic [RW-1:0] r;
	logic [DW-1:0] c_next;
	logic          wrap_n;
	logic [HW-1:0] r_next;
	logic          accept;

	// stage 1: pixel with its line-store reads
	logic          s1_valid_q;
	logic [7:0]    gray_s1;
	logic [CW-1:0] addr_s1;
	logic          prod_s1;
	logic [PW-1:0] row_s1;
	logic [PW-1:0] col_s1;
	logic          fe_s1;
	logic [7:0]    rd_above;
	logic [7:0]    rd_two;
	logic          adv1;

	// columns c-2 (0..2) and c-1 (3..5), top to bottom
	logic [7:0] win_q [6];

	logic signed [11:0] gx_w;
	logic signed [11:0] gy_w;

	logic                 grad_valid_q;
	sedt_pkg::sedt_grad_t grad_q;

	// position of the arriving pixel, after any wrap left by a geometry change
	always_comb begin
		col_wrap = DW'(col_q) >= frame_w;
		c        = col_wrap ? '0 : col_q;
		row_p    = HW'(row_q) + HW'(col_wrap);
		r        = (row_p >= frame_h) ? '0 : row_p[RW-1:0];
		c_next   = DW'(c) + DW'(1'b1);
		wrap_n   = c_next >= frame_w;
		r_next   = HW'(r) + HW'(1'b1);
	end

	assign adv1      = s1_valid_q && (!prod_s1 || !grad_valid_q || grad_ready);
	assign pix.ready = !s1_valid_q || adv1;
	assign accept    = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (wrap_n) begin
					col_q <= '0;
					row_q <= (r_next >= frame_h) ? '0 : r_next[RW-1:0];
				end else begin
					col_q <= c_next[CW-1:0];
					row_q <= r;
				end
			end else if (adv1) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1 <= sedt_pkg::gray_of(pix.red, pix.green, pix.blue);
			addr_s1 <= c;
			prod_s1 <= (r >= RW'(2)) && (c >= CW'(2));
			row_s1  <= PW'(r - RW'(1));
			col_s1  <= PW'(c - CW'(1));
			fe_s1   <= (HW'(r) == frame_h - HW'(1'b1)) && (DW'(c) == frame_w - DW'(1'b1));
		end
	end

	// line stores: read on transfer, written back when the pixel leaves stage 1
	sedt_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_above (
		.clk   (clk),
		.we    (adv1),
		.waddr (addr_s1),
		.wdata (gray_s1),
		.re    (accept),
		.raddr (c),
		.rdata (rd_above)
	);

	sedt_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_line_two_above (
		.clk   (clk),
		.we    (adv1),
		.waddr (addr_s1),
		.wdata (rd_above),
		.re    (accept),
		.raddr (c),
		.rdata (rd_two)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (adv1) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= rd_two;
			win_q[4] <= rd_above;
			win_q[5] <= gray_s1;
		end
	end

	always_comb begin
		gx_w = ($signed({4'b0, win_q[0]}) - $signed({4'b0, rd_two}))
		     + 12'sd2 * ($signed({4'b0, win_q[1]}) - $signed({4'b0, rd_above}))
		     + ($signed({4'b0, win_q[2]}) - $signed({4'b0, gray_s1}));
		gy_w = ($signed({4'b0, win_q[0]}) + 12'sd2 * $signed({4'b0, win_q[3]})
		      + $signed({4'b0, rd_two}))
		     - ($signed({4'b0, win_q[2]}) + 12'sd2 * $signed({4'b0, win_q[5]})
		      + $signed({4'b0, gray_s1}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grad_valid_q <= 1'b0;
		end else if (adv1 && prod_s1) begin
			grad_valid_q <= 1'b1;
		end else if (grad_ready) begin
			grad_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && prod_s1) begin
			grad_q.gx        <= sedt_pkg::GRAD_W'(gx_w);
			grad_q.gy        <= sedt_pkg::GRAD_W'(gy_w);
			grad_q.row       <= row_s1;
			grad_q.col       <= col_s1;
			grad_q.frame_end <= fe_s1;
		end
	end

	assign grad_valid = grad_valid_q;
	assign grad       = grad_q;

	// a held stage-1 pixel must keep its line-store data
	`SEDT_ASSERT_NXT(a_rd_hold, clk, arst_n, s1_valid_q && !adv1, $stable(rd_above) && $stable(rd_two))
	// the last interior pixel sits one column left of the right border
	`SEDT_ASSERT_IMP(a_fe_col, clk, arst_n, grad_valid_q && grad_q.frame_end, grad_q.col == PW'(frame_w - DW'(2)))

endmodule

FILE: sv/sedt_classify.sv
// Squared gradient magnitude and double-threshold classification.
`timescale 1ns / 1ps
`include "sobel_edge_double_threshold_top_macros.svh"

module sedt_classify (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                grad_valid,
	output logic                                grad_ready,
	input  sedt_pkg::sedt_grad_t                grad,
	input  logic [sedt_pkg::THR_W-1:0]          low_thr,
	input  logic [sedt_pkg::THR_W-1:0]          high_thr,
	sedt_edge_if.source                         res
);

	localparam int PW = sedt_pkg::POS_W;
	localparam int MW = sedt_pkg::MAG_W;

	logic [9:0]  ax;
	logic [9:0]  ay;
	logic [19:0] sx;
	logic [19:0] sy;

	logic          s3_valid_q;
	logic [MW-1:0] mag_s3;
	logic [PW-1:0] row_s3;
	logic [PW-1:0] col_s3;
	logic          fe_s3;
	logic          adv3;

	logic [sedt_pkg::THR_W-1:0] lo;
	logic [sedt_pkg::THR_W-1:0] hi;
	sedt_pkg::sedt_class_t      cls;

	logic                  out_valid_q;
	sedt_pkg::sedt_class_t class_q;
	logic [PW-1:0]         row_q;
	logic [PW-1:0]         col_q;
	logic                  fe_q;

	always_comb begin
		ax = grad.gx[sedt_pkg::GRAD_W-1] ? 10'(-grad.gx) : 10'(grad.gx);
		ay = grad.gy[sedt_pkg::GRAD_W-1] ? 10'(-grad.gy) : 10'(grad.gy);
		sx = 20'(ax) * 20'(ax);
		sy = 20'(ay) * 20'(ay);
	end

	assign adv3       = s3_valid_q && (!out_valid_q || res.ready);
	assign grad_ready = !s3_valid_q || adv3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid_q <= 1'b0;
		end else if (grad_valid && grad_ready) begin
			s3_valid_q <= 1'b1;
		end else if (adv3) begin
			s3_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (grad_valid && grad_ready) begin
			mag_s3 <= MW'(sx) + MW'(sy);
			row_s3 <= grad.row;
			col_s3 <= grad.col;
			fe_s3  <= grad.frame_end;
		end
	end

	// thresholds exchanged when given out of order; both compares strict
	always_comb begin
		if (low_thr > high_thr) begin
			lo = high_thr;
			hi = low_thr;
		end else begin
			lo = low_thr;
			hi = high_thr;
		end
		if (mag_s3 > hi) begin
			cls = sedt_pkg::EDGE_STRONG;
		end else if (mag_s3 > lo) begin
			cls = sedt_pkg::EDGE_WEAK;
		end else begin
			cls = sedt_pkg::EDGE_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv3) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			class_q <= cls;
			row_q   <= row_s3;
			col_q   <= col_s3;
			fe_q    <= fe_s3;
		end
	end

	assign res.valid      = out_valid_q;
	assign res.edge_class = class_q;
	assign res.pixel_row  = row_q;
	assign res.pixel_col  = col_q;
	assign res.frame_end  = fe_q;

	`SEDT_ASSERT_NXT(a_strong, clk, arst_n, adv3 && (mag_s3 > low_thr) && (mag_s3 > high_thr), res.edge_class == sedt_pkg::EDGE_STRONG)
	`SEDT_ASSERT_NXT(a_none, clk, arst_n, adv3 && (mag_s3 <= low_thr) && (mag_s3 <= high_thr), res.edge_class == sedt_pkg::EDGE_NONE)

endmodule

FILE: sv/sobel_edge_double_threshold_top.sv
// Sobel 3x3 edge classifier with double threshold: one RGB pixel per clock in
// raster order, gray = floor((R+G+B)/3), two line stores of MAX_WIDTH entries
// and a 3x3 window. Each interior pixel gets one result: none, weak (gx^2+gy^2
// above the low threshold) or strong (above the high one; the thresholds are
// exchanged if low exceeds high). Border pixels give no result. The block
// takes one pixel every clock while the result side keeps up. A result passes
// the line-store read, gradient, squared magnitude and compare registers
// after the transfer of the pixel completing its window. The line stores need
// no clearing after reset. The user must write geometry and thresholds via
// cfg_we/cfg_index/cfg_data only while no pixel is in flight; not enforced.
`timescale 1ns / 1ps

module sobel_edge_double_threshold_top #(
	parameter int MAX_WIDTH  = sedt_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sedt_pkg::MAX_HEIGHT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	sedt_pix_if.sink                          pix,
	sedt_edge_if.source                       res,
	input  logic                              cfg_we,
	input  logic [sedt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sedt_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int DW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	logic [sedt_pkg::DIM_W-1:0] frame_width_q;
	logic [sedt_pkg::DIM_W-1:0] frame_height_q;
	logic [sedt_pkg::THR_W-1:0] low_thr_q;
	logic [sedt_pkg::THR_W-1:0] high_thr_q;

	logic [DW-1:0] frame_w;
	logic [HW-1:0] frame_h;

	logic                 grad_valid;
	logic                 grad_ready;
	sedt_pkg::sedt_grad_t grad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sedt_pkg::FRAME_WIDTH_RST;
			frame_height_q <= sedt_pkg::FRAME_HEIGHT_RST;
			low_thr_q      <= sedt_pkg::LOW_THR_RST;
			high_thr_q     <= sedt_pkg::HIGH_THR_RST;
		end else if (cfg_we) begin
			case (sedt_pkg::sedt_reg_t'(cfg_index))
				sedt_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[sedt_pkg::DIM_W-1:0];
				sedt_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[sedt_pkg::DIM_W-1:0];
				sedt_pkg::REG_LOW_THR:      low_thr_q      <= cfg_data[sedt_pkg::THR_W-1:0];
				sedt_pkg::REG_HIGH_THR:     high_thr_q     <= cfg_data[sedt_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// effective geometry, clamped to 3..MAX
	always_comb begin
		if (frame_width_q < 12'd3) begin
			frame_w = DW'(3);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			frame_w = DW'(MAX_WIDTH);
		end else begin
			frame_w = DW'(frame_width_q);
		end
		if (frame_height_q < 12'd3) begin
			frame_h = HW'(3);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			frame_h = HW'(MAX_HEIGHT);
		end else begin
			frame_h = HW'(frame_height_q);
		end
	end

	sedt_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.frame_w    (frame_w),
		.frame_h    (frame_h),
		.grad_valid (grad_valid),
		.grad_ready (grad_ready),
		.grad       (grad)
	);

	sedt_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.grad_valid (grad_valid),
		.grad_ready (grad_ready),
		.grad       (grad),
		.low_thr    (low_thr_q),
		.high_thr   (high_thr_q),
		.res        (res)
	);

endmodule
